// ----- sv/xmef_pkg.sv -----
// ----------------------------------------------------------------------------
// xmef_pkg
// Shared types, character constants and prefix tables for the XML markup
// end finder.
// ----------------------------------------------------------------------------
package xmef_pkg;

    // Default width of the saturating length counter.
    localparam int unsigned LENGTH_BITS_DEF = 16;
    // Width of the reported length field.
    localparam int unsigned OUT_LEN_W = 16;

    // Characters examined by the scanner.
    localparam logic [7:0] CH_LT     = 8'h3C;
    localparam logic [7:0] CH_GT     = 8'h3E;
    localparam logic [7:0] CH_BANG   = 8'h21;
    localparam logic [7:0] CH_QMARK  = 8'h3F;
    localparam logic [7:0] CH_DASH   = 8'h2D;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_RBRACK = 8'h5D;
    localparam logic [7:0] CH_C      = 8'h43;
    localparam logic [7:0] CH_D      = 8'h44;
    localparam logic [7:0] CH_A      = 8'h41;
    localparam logic [7:0] CH_T      = 8'h54;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_DQUOTE = 8'h22;

    // Prefix lengths including the opening '<'.
    localparam logic [3:0] PFX_LEN_COMMENT = 4'd4;
    localparam logic [3:0] PFX_LEN_PI      = 4'd2;
    localparam logic [3:0] PFX_LEN_CDATA   = 4'd9;

    // Candidate bit positions.
    localparam int unsigned CAND_COMMENT = 0;
    localparam int unsigned CAND_PI      = 1;
    localparam int unsigned CAND_CDATA   = 2;

    typedef enum logic [1:0] {
        PH_IDLE   = 2'd0,
        PH_PREFIX = 2'd1,
        PH_BODY   = 2'd2,
        PH_DONE   = 2'd3
    } t_phase;

    typedef enum logic [1:0] {
        KIND_TAG     = 2'd0,
        KIND_COMMENT = 2'd1,
        KIND_PI      = 2'd2,
        KIND_CDATA   = 2'd3
    } t_kind;

    // Per-markup scan state, apart from the length counter.
    typedef struct packed {
        t_phase     phase;
        t_kind      kind;
        logic [3:0] pidx;      // position of the next prefix byte
        logic [2:0] cand;      // prefix candidates still alive
        logic       in_quote;
        logic       q_dbl;     // open quote is a double quote
        logic [1:0] tail;      // terminator lead bytes seen
    } t_scan_state;

    localparam t_scan_state SCAN_RESET = '{
        phase:    PH_IDLE,
        kind:     KIND_TAG,
        pidx:     4'd0,
        cand:     3'd0,
        in_quote: 1'b0,
        q_dbl:    1'b0,
        tail:     2'd0
    };

    // Result of one prefix step.
    typedef struct packed {
        logic [2:0] keep;      // candidates that still match
        logic       complete;  // a prefix finished on this byte
        t_kind      kind;      // kind of the finished prefix
    } t_pfx_res;

    // Character expected at a prefix position; positions past the end never match.
    function automatic logic pfx_match(input t_kind sel, input logic [3:0] idx,
                                       input logic [7:0] b);
        logic [7:0] c;
        logic       ok;
        c  = CH_LT;
        ok = 1'b0;
        case (sel)
            KIND_COMMENT: begin
                ok = (idx < PFX_LEN_COMMENT);
                case (idx)
                    4'd1:    c = CH_BANG;
                    4'd2:    c = CH_DASH;
                    4'd3:    c = CH_DASH;
                    default: c = CH_LT;
                endcase
            end
            KIND_PI: begin
                ok = (idx < PFX_LEN_PI);
                c  = (idx == 4'd1) ? CH_QMARK : CH_LT;
            end
            KIND_CDATA: begin
                ok = (idx < PFX_LEN_CDATA);
                case (idx)
                    4'd1:    c = CH_BANG;
                    4'd2:    c = CH_LBRACK;
                    4'd3:    c = CH_C;
                    4'd4:    c = CH_D;
                    4'd5:    c = CH_A;
                    4'd6:    c = CH_T;
                    4'd7:    c = CH_A;
                    4'd8:    c = CH_LBRACK;
                    default: c = CH_LT;
                endcase
            end
            default: ok = 1'b0;
        endcase
        return ok && (c == b);
    endfunction

    // Terminator lead byte for each kind.
    function automatic logic [7:0] term_lead(input t_kind k);
        logic [7:0] c;
        case (k)
            KIND_COMMENT: c = CH_DASH;
            KIND_PI:      c = CH_QMARK;
            KIND_CDATA:   c = CH_RBRACK;
            default:      c = 8'd0;
        endcase
        return c;
    endfunction

    // Number of lead bytes that precede the closing '>'.
    function automatic logic [1:0] term_reps(input t_kind k);
        logic [1:0] r;
        case (k)
            KIND_COMMENT: r = 2'd2;
            KIND_PI:      r = 2'd1;
            KIND_CDATA:   r = 2'd2;
            default:      r = 2'd0;
        endcase
        return r;
    endfunction

endpackage

// ----- sv/xmef_in_if.sv -----
// ----------------------------------------------------------------------------
// xmef_in_if
// Input channel: one markup byte and its start flag per transfer.
// ----------------------------------------------------------------------------
interface xmef_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       markup_start;

    modport source (output valid, output data_byte, output markup_start, input ready);
    modport sink   (input valid, input data_byte, input markup_start, output ready);
endinterface

// ----- sv/xmef_out_if.sv -----
// ----------------------------------------------------------------------------
// xmef_out_if
// Result channel: end flag, kind and length for each byte taken.
// ----------------------------------------------------------------------------
interface xmef_out_if;
    logic        valid;
    logic        ready;
    logic        end_found;
    logic [1:0]  markup_kind;
    logic        classified;
    logic [15:0] markup_length;

    modport source (output valid, output end_found, output markup_kind,
                    output classified, output markup_length, input ready);
    modport sink   (input valid, input end_found, input markup_kind,
                    input classified, input markup_length, output ready);
endinterface

// ----- sv/xmef_prefix.sv -----
// ----------------------------------------------------------------------------
// xmef_prefix
// Matches one byte against the comment, PI and CDATA prefixes and reports
// which candidates survive and whether a prefix has completed.
// ----------------------------------------------------------------------------
module xmef_prefix
    import xmef_pkg::*;
(
    input  logic [3:0] i_index,
    input  logic [2:0] i_cand,
    input  logic [7:0] i_byte,
    output t_pfx_res   o_res
);

    logic [2:0] keep;

    // Each candidate survives when its character at this position matches.
    assign keep[CAND_COMMENT] = i_cand[CAND_COMMENT] && pfx_match(KIND_COMMENT, i_index, i_byte);
    assign keep[CAND_PI]      = i_cand[CAND_PI]      && pfx_match(KIND_PI, i_index, i_byte);
    assign keep[CAND_CDATA]   = i_cand[CAND_CDATA]   && pfx_match(KIND_CDATA, i_index, i_byte);

    // The prefixes complete at distinct positions, so at most one fires.
    always_comb begin
        o_res.keep     = keep;
        o_res.complete = 1'b0;
        o_res.kind     = KIND_TAG;
        if (keep[CAND_COMMENT] && i_index == PFX_LEN_COMMENT - 4'd1) begin
            o_res.complete = 1'b1;
            o_res.kind     = KIND_COMMENT;
        end else if (keep[CAND_PI] && i_index == PFX_LEN_PI - 4'd1) begin
            o_res.complete = 1'b1;
            o_res.kind     = KIND_PI;
        end else if (keep[CAND_CDATA] && i_index == PFX_LEN_CDATA - 4'd1) begin
            o_res.complete = 1'b1;
            o_res.kind     = KIND_CDATA;
        end
    end

endmodule

// ----- sv/xmef_step.sv -----
// ----------------------------------------------------------------------------
// xmef_step
// Next-state logic for one byte: prefix classification, quote tracking for
// tags, terminator matching and the saturating length count.
// ----------------------------------------------------------------------------
module xmef_step
    import xmef_pkg::*;
#(
    parameter int unsigned LENGTH_BITS = LENGTH_BITS_DEF
) (
    input  t_scan_state            i_state,
    input  logic [LENGTH_BITS-1:0] i_len,
    input  logic [7:0]             i_byte,
    input  logic                   i_start,
    output t_scan_state            o_state,
    output logic [LENGTH_BITS-1:0] o_len,
    output logic                   o_found
);

    t_pfx_res   pfx;
    logic       tag_mode;
    logic [7:0] lead;
    logic [1:0] reps;
    logic [7:0] open_quote;

    xmef_prefix u_prefix (
        .i_index (i_state.pidx),
        .i_cand  (i_state.cand),
        .i_byte  (i_byte),
        .o_res   (pfx)
    );

    assign lead       = term_lead(i_state.kind);
    assign reps       = term_reps(i_state.kind);
    assign open_quote = i_state.q_dbl ? CH_DQUOTE : CH_SQUOTE;

    // A byte is tag content in the body of a tag, or when the prefix fails.
    assign tag_mode = (i_state.phase == PH_BODY && i_state.kind == KIND_TAG) ||
                      (i_state.phase == PH_PREFIX && pfx.keep == 3'd0);

    always_comb begin
        o_state = i_state;
        o_len   = i_len;
        o_found = 1'b0;
        if (i_start) begin
            // Start byte opens new markup whatever its value.
            o_state       = SCAN_RESET;
            o_state.phase = PH_PREFIX;
            o_state.pidx  = 4'd1;
            o_state.cand  = 3'b111;
            o_len         = {{(LENGTH_BITS-1){1'b0}}, 1'b1};
        end else if (i_state.phase == PH_PREFIX || i_state.phase == PH_BODY) begin
            if (i_len != {LENGTH_BITS{1'b1}}) begin
                o_len = i_len + {{(LENGTH_BITS-1){1'b0}}, 1'b1};
            end

            // Prefix bookkeeping.
            if (i_state.phase == PH_PREFIX) begin
                o_state.cand = pfx.keep;
                if (pfx.keep == 3'd0) begin
                    o_state.kind  = KIND_TAG;
                    o_state.phase = PH_BODY;
                end else if (pfx.complete) begin
                    o_state.kind  = pfx.kind;
                    o_state.phase = PH_BODY;
                    o_state.tail  = 2'd0;
                end else begin
                    o_state.pidx = i_state.pidx + 4'd1;
                end
            end

            if (tag_mode) begin
                // Tag content: quotes hide '>' until they close.
                if (i_state.in_quote) begin
                    if (i_byte == open_quote) begin
                        o_state.in_quote = 1'b0;
                    end
                end else if (i_byte == CH_SQUOTE || i_byte == CH_DQUOTE) begin
                    o_state.in_quote = 1'b1;
                    o_state.q_dbl    = (i_byte == CH_DQUOTE);
                end else begin
                    o_found = (i_byte == CH_GT);
                end
            end else if (i_state.phase == PH_BODY) begin
                // Terminator run: lead bytes counted up to the needed repeat.
                if (i_byte == lead) begin
                    if (i_state.tail < reps) begin
                        o_state.tail = i_state.tail + 2'd1;
                    end
                end else if (i_byte == CH_GT && i_state.tail == reps) begin
                    o_found = 1'b1;
                end else begin
                    o_state.tail = 2'd0;
                end
            end

            if (o_found) begin
                o_state.phase = PH_DONE;
            end
        end
    end

endmodule

// ----- sv/xml_markup_end_finder.sv -----
// ----------------------------------------------------------------------------
// xml_markup_end_finder
// Finds the end of XML markup in a byte stream and classifies it.
// Each result is registered and appears in the cycle after its byte transfer.
// Throughput: one byte per cycle while the result side keeps up; the state update is a single registered step.
// The output register frees the input side whenever the result is taken.
// Reset (synchronous, active low) clears the scan state and the result valid.
// ----------------------------------------------------------------------------
module xml_markup_end_finder
    import xmef_pkg::*;
#(
    parameter int unsigned LENGTH_BITS = LENGTH_BITS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    xmef_in_if.sink    i_item,
    xmef_out_if.source o_result
);

    t_scan_state                    r_state;
    t_scan_state                    n_state;
    logic [LENGTH_BITS-1:0]         r_len;
    logic [LENGTH_BITS-1:0]         n_len;
    logic                           n_found;
    logic                           take;
    logic [LENGTH_BITS+OUT_LEN_W-1:0] len_wide;

    logic                 r_out_valid;
    logic                 r_found;
    t_kind                r_kind;
    logic                 r_classified;
    logic [OUT_LEN_W-1:0] r_out_len;

    // A new byte is taken whenever the result register is empty or draining.
    assign i_item.ready = !r_out_valid || o_result.ready;
    assign take         = i_item.valid && i_item.ready;

    xmef_step #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_step (
        .i_state (r_state),
        .i_len   (r_len),
        .i_byte  (i_item.data_byte),
        .i_start (i_item.markup_start),
        .o_state (n_state),
        .o_len   (n_len),
        .o_found (n_found)
    );

    // Reported length is the low bits of the counter.
    assign len_wide = {{OUT_LEN_W{1'b0}}, n_len};

    // Scan state and result valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= SCAN_RESET;
            r_len       <= '0;
            r_out_valid <= 1'b0;
        end else if (take) begin
            r_state     <= n_state;
            r_len       <= n_len;
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Result payload.
    always_ff @(posedge i_clk) begin
        if (take) begin
            r_found      <= n_found;
            r_kind       <= n_state.kind;
            r_classified <= (n_state.phase == PH_BODY) || (n_state.phase == PH_DONE);
            r_out_len    <= len_wide[OUT_LEN_W-1:0];
        end
    end

    assign o_result.valid         = r_out_valid;
    assign o_result.end_found     = r_found;
    assign o_result.markup_kind   = r_kind;
    assign o_result.classified    = r_classified;
    assign o_result.markup_length = r_out_len;

endmodule

// ----- test/tb_xml_markup_end_finder.sv -----
// ----------------------------------------------------------------------------
// tb_xml_markup_end_finder
// Self-checking bench for the XML markup end finder. A byte-level scan
// tracker predicts the end flag, kind, classified flag and saturating length
// of every accepted byte. Each result transfer is compared with the oldest
// prediction. Stimulus is a short directed sequence followed by random
// markup streams. The sender works in bursts and the receiver stalls on its
// own pattern.
// ----------------------------------------------------------------------------
module tb_xml_markup_end_finder;
    import xmef_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [15:0] LEN_MAX     = 16'hFFFF;
    localparam int          STALL_LIMIT = 2000;   // above the longest hold-off, HOLD_CYCLES
    localparam int          HOLD_CYCLES = 300;
    localparam int          RANDOM_ITEMS = 870;

    // One result of the scanner, as seen on the result channel.
    typedef struct packed {
        logic        end_found;
        logic [1:0]  kind;
        logic        classified;
        logic [15:0] length;
    } t_scan_report;

    // Tracks the scan state byte by byte and holds the reports still owed.
    class markup_end_tracker;
        string        openers[3] = '{"<!--", "<?", "<![CDATA["};
        string        closers[3] = '{"-->", "?>", "]]>"};
        t_phase       phase;
        t_kind        kind;
        logic [3:0]   pidx;
        logic [2:0]   cand;
        logic         in_quote;
        logic [7:0]   quote_char;
        logic [1:0]   tail;
        logic [15:0]  len;
        t_scan_report expected_reports[$];
        int           errors;

        function new();
            clear_scan();
            errors = 0;
        endfunction

        function void clear_scan();
            phase      = PH_IDLE;
            kind       = KIND_TAG;
            pidx       = 4'd0;
            cand       = 3'd0;
            in_quote   = 1'b0;
            quote_char = 8'h00;
            tail       = 2'd0;
            len        = 16'd0;
        endfunction

        function int pending();
            return expected_reports.size();
        endfunction

        // Quote tracking for tags; only a '>' outside quotes ends the tag.
        function logic tag_content(input logic [7:0] b);
            if (in_quote) begin
                if (b == quote_char) in_quote = 1'b0;
                return 1'b0;
            end
            if (b == CH_SQUOTE || b == CH_DQUOTE) begin
                in_quote   = 1'b1;
                quote_char = b;
                return 1'b0;
            end
            return b == CH_GT;
        endfunction

        // Terminator search; the lead run count sticks at its full length.
        function logic closer_content(input logic [7:0] b);
            logic [7:0] lead;
            logic [1:0] reps;
            case (kind)
                KIND_COMMENT: begin lead = CH_DASH;   reps = 2'd2; end
                KIND_PI:      begin lead = CH_QMARK;  reps = 2'd1; end
                KIND_CDATA:   begin lead = CH_RBRACK; reps = 2'd2; end
                default:      begin lead = 8'h00;     reps = 2'd0; end
            endcase
            if (b == lead) begin
                if (tail < reps) tail = tail + 2'd1;
                return 1'b0;
            end
            if (b == CH_GT && tail == reps) return 1'b1;
            tail = 2'd0;
            return 1'b0;
        endfunction

        // Narrows the prefix candidates; a dead end turns the markup into a tag.
        function logic prefix_content(input logic [7:0] b);
            logic [2:0] keep;
            keep = 3'd0;
            for (int i = 0; i < 3; i++) begin
                if (cand[i] && pidx < openers[i].len() && openers[i][pidx] == b)
                    keep[i] = 1'b1;
            end
            cand = keep;
            if (keep == 3'd0) begin
                kind  = KIND_TAG;
                phase = PH_BODY;
                return tag_content(b);
            end
            for (int i = 0; i < 3; i++) begin
                if (keep[i] && int'(pidx) + 1 == openers[i].len()) begin
                    kind  = t_kind'(i + 1);
                    phase = PH_BODY;
                    tail  = 2'd0;
                    return 1'b0;
                end
            end
            pidx = pidx + 4'd1;
            return 1'b0;
        endfunction

        // Notes an accepted byte and queues the report it must produce.
        function void take_byte(input logic [7:0] b, input logic start);
            logic         found;
            t_scan_report rep;
            found = 1'b0;
            if (start) begin
                clear_scan();
                phase = PH_PREFIX;
                pidx  = 4'd1;
                cand  = 3'b111;
                len   = 16'd1;
            end else if (phase == PH_PREFIX || phase == PH_BODY) begin
                if (len != LEN_MAX) len = len + 16'd1;
                if (phase == PH_PREFIX)   found = prefix_content(b);
                else if (kind == KIND_TAG) found = tag_content(b);
                else                      found = closer_content(b);
                if (found) phase = PH_DONE;
            end
            rep.end_found  = found;
            rep.kind       = kind;
            rep.classified = (phase == PH_BODY || phase == PH_DONE);
            rep.length     = len;
            expected_reports.insert(expected_reports.size(), rep);
        endfunction

        function void report_mismatch(input string field, input logic [15:0] want,
                                      input logic [15:0] got);
            errors++;
            $display("%0t: %s mismatch, expected %0h, actual %0h",
                     $time, field, want, got);
        endfunction

        // Compares one result transfer with the oldest queued report.
        function void check_report(input t_scan_report got);
            t_scan_report want;
            if (expected_reports.size() == 0) begin
                errors++;
                $display("%0t: unexpected result, expected none, actual %0h",
                         $time, got);
                return;
            end
            want = expected_reports.pop_front();
            if (got.end_found !== want.end_found)
                report_mismatch("end_found", 16'(want.end_found), 16'(got.end_found));
            if (got.kind !== want.kind)
                report_mismatch("markup_kind", 16'(want.kind), 16'(got.kind));
            if (got.classified !== want.classified)
                report_mismatch("classified", 16'(want.classified), 16'(got.classified));
            if (got.length !== want.length)
                report_mismatch("markup_length", want.length, got.length);
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;

    xmef_in_if  in_ch();
    xmef_out_if out_ch();

    xml_markup_end_finder i_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (in_ch),
        .o_result (out_ch)
    );

    markup_end_tracker tracker = new();

    int   items_sent  = 0;
    int   burst_left  = 0;
    logic no_gaps     = 1'b0;
    logic hold_req    = 1'b0;
    int   idle_cycles = 0;

    // Free-running clock, 10 ns period.
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Sends one byte, waits for its transfer, then maybe pauses between bursts.
    task automatic send_byte(input logic [7:0] b, input logic start);
        int gap;
        in_ch.valid        <= 1'b1;
        in_ch.data_byte    <= b;
        in_ch.markup_start <= start;
        do @(posedge i_clk); while (in_ch.ready !== 1'b1);
        tracker.take_byte(b, start);
        items_sent++;
        if (burst_left > 0) burst_left--;
        if (burst_left == 0 && !no_gaps) begin
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 150)
                                                     : $urandom_range(1, 16);
            if (gap > 0) begin
                in_ch.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    task automatic send_text(input string s);
        for (int j = 0; j < s.len(); j++) send_byte(s[j], 1'b0);
    endtask

    // Stops offering bytes until every queued report has come back.
    task automatic drain_results();
        in_ch.valid <= 1'b0;
        do @(posedge i_clk); while (tracker.pending() != 0);
    endtask

    // Body byte biased toward the characters the scanner reacts to.
    function automatic logic [7:0] pick_body_byte(input logic [7:0] lead);
        case ($urandom_range(0, 11))
            0, 1, 2: return lead;
            3:       return CH_GT;
            4:       return CH_DQUOTE;
            5:       return CH_SQUOTE;
            6:       return CH_DASH;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // One random markup: well formed most of the time, sometimes broken or cut.
    task automatic send_markup();
        int         choice;
        int         k;
        int         n;
        int         cut;
        logic       cut_short;
        logic       in_q;
        logic [7:0] qc;
        logic [7:0] b;
        choice    = $urandom_range(0, 99);
        cut_short = ($urandom_range(0, 9) == 0);
        in_q      = 1'b0;
        qc        = 8'h00;
        if (choice < 8) begin
            // Stray bytes with no start flag.
            n = $urandom_range(1, 4);
            repeat (n) send_byte(8'($urandom_range(0, 255)), 1'b0);
            return;
        end
        send_byte(($urandom_range(0, 7) == 0) ? 8'($urandom_range(0, 255)) : CH_LT, 1'b1);
        if (choice >= 40 && choice < 85) begin
            // Comment, processing instruction or CDATA with a random body.
            k = (choice - 40) / 15;
            for (int j = 1; j < tracker.openers[k].len(); j++)
                send_byte(tracker.openers[k][j], 1'b0);
            n = $urandom_range(0, 12);
            repeat (n) send_byte(pick_body_byte(tracker.closers[k][0]), 1'b0);
            if (!cut_short) send_text(tracker.closers[k]);
            return;
        end
        n = $urandom_range(0, 10);
        if (choice >= 85) begin
            // Part of a prefix, then tag content that breaks it.
            k   = $urandom_range(0, 2);
            cut = $urandom_range(1, tracker.openers[k].len() - 1);
            for (int j = 1; j < cut; j++) send_byte(tracker.openers[k][j], 1'b0);
            if (n == 0) n = 1;
        end
        // Tag content; a bare '>' outside quotes is kept for the end.
        repeat (n) begin
            b = pick_body_byte(8'h3D);
            if (in_q) begin
                if (b == qc) in_q = 1'b0;
            end else if (b == CH_SQUOTE || b == CH_DQUOTE) begin
                in_q = 1'b1;
                qc   = b;
            end else if (b == CH_GT) begin
                b = 8'h61;
            end
            send_byte(b, 1'b0);
        end
        if (!cut_short) begin
            if (in_q) send_byte(qc, 1'b0);
            send_byte(CH_GT, 1'b0);
        end
    endtask

    // Result receiver: stall patterns that change every stretch, plus hold-offs.
    initial begin
        int   mode;
        int   stretch_left;
        int   hold_left;
        int   tick;
        logic rdy;
        mode         = 0;
        stretch_left = 0;
        hold_left    = 0;
        tick         = 0;
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            tick++;
            if (hold_req) begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                rdy = 1'b0;
            end else begin
                if (stretch_left == 0) begin
                    mode         = $urandom_range(0, 3);
                    stretch_left = $urandom_range(20, 200);
                end
                stretch_left--;
                case (mode)
                    0:       rdy = 1'b1;
                    1:       rdy = 1'($urandom_range(0, 1));
                    2:       rdy = ($urandom_range(0, 9) != 0);
                    default: rdy = (tick % 4 != 3);
                endcase
            end
            out_ch.ready <= rdy;
        end
    end

    // Result checker.
    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid === 1'b1 && out_ch.ready === 1'b1)
            tracker.check_report('{end_found:  out_ch.end_found,
                                   kind:       out_ch.markup_kind,
                                   classified: out_ch.classified,
                                   length:     out_ch.markup_length});
    end

    // Watchdog on cycles with no transfer on either channel.
    always @(posedge i_clk) begin
        if ((in_ch.valid === 1'b1 && in_ch.ready === 1'b1) ||
            (out_ch.valid === 1'b1 && out_ch.ready === 1'b1))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    // Main sequence.
    initial begin
        int   base;
        logic pressed;
        logic drained;
        pressed             = 1'b0;
        drained             = 1'b0;
        i_rst_n            <= 1'b0;
        in_ch.valid        <= 1'b0;
        in_ch.data_byte    <= 8'h00;
        in_ch.markup_start <= 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Comment opened by a start byte that is not '<'; '>' right after the
        // prefix does not close it, and a run of three dashes does.
        send_byte(8'hFF, 1'b1);
        send_text("!-->--->");
        // Byte after the end with no start flag is ignored.
        send_byte(8'h00, 1'b0);
        // Processing instruction whose prefix is followed by '>'.
        send_byte(CH_LT, 1'b1);
        send_text("?>?>");
        // Broken prefix falling back to a tag on a quote.
        send_byte(CH_LT, 1'b1);
        send_text("!\">\">");
        // New markup while a tag is open, then a quote that never closes.
        send_byte(CH_LT, 1'b1);
        send_text("a");
        send_byte(CH_LT, 1'b1);
        send_text("'>");
        drain_results();

        // Random markup streams.
        base = items_sent;
        while (items_sent - base < RANDOM_ITEMS) begin
            if (!pressed && items_sent - base >= 300) begin
                // Long receiver hold-off while the sender keeps offering.
                pressed  = 1'b1;
                hold_req = 1'b1;
                no_gaps  = 1'b1;
                send_byte(CH_LT, 1'b1);
                repeat (60) send_byte(8'h61, 1'b0);
                no_gaps  = 1'b0;
            end
            if (!drained && items_sent - base >= 600) begin
                drained = 1'b1;
                drain_results();
            end
            send_markup();
        end

        drain_results();
        repeat (5) @(posedge i_clk);
        if (tracker.errors == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
sv/xmef_pkg.sv
sv/xmef_in_if.sv
sv/xmef_out_if.sv
sv/xmef_prefix.sv
sv/xmef_step.sv
sv/xml_markup_end_finder.sv
test/tb_xml_markup_end_finder.sv
